### rtl/pcpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpu_pkg
// Shared types, constants and helpers for the pattern count point update unit.
// ----------------------------------------------------------------------------
package pcpu_pkg;

  // store geometry and field widths
  localparam int MAX_LEN  = 4096;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int LEN_W    = 13;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 11;

  // neighborhood around the written byte: five taps, three windows
  localparam int TAP_N      = 5;
  localparam int WIN_N      = 3;
  localparam int CENTER_TAP = 2;
  localparam int TAP_CNT_W  = $clog2(TAP_N + 1);

  // pattern bytes
  localparam logic [CHAR_W-1:0] PAT0 = 8'h41;
  localparam logic [CHAR_W-1:0] PAT1 = 8'h42;
  localparam logic [CHAR_W-1:0] PAT2 = 8'h43;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // control states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE
  } state_t;

  // input beat
  typedef struct packed {
    logic [ADDR_W-1:0] position;
    logic [CHAR_W-1:0] new_char;
  } in_t;

  // result beat
  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               ignored;
  } out_t;

  // neighborhood bytes and window qualifiers handed to the match logic
  typedef struct packed {
    logic [TAP_N-1:0][CHAR_W-1:0] taps;
    logic [WIN_N-1:0]             valid;
  } win_t;

  // three consecutive bytes equal the pattern
  function automatic logic is_abc(input logic [CHAR_W-1:0] b0,
                                  input logic [CHAR_W-1:0] b1,
                                  input logic [CHAR_W-1:0] b2);
    return (b0 == PAT0) && (b1 == PAT1) && (b2 == PAT2);
  endfunction

endpackage

### rtl/pcpu_match_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpu_match_delta
// Counts pattern hits in the windows covering the written byte, before and
// after the write, and returns the signed change in the occurrence count.
// ----------------------------------------------------------------------------
module pcpu_match_delta (
  input  pcpu_pkg::win_t                  win_i,
  input  logic [pcpu_pkg::CHAR_W-1:0]     new_char_i,
  output logic signed [2:0]               delta_o
);

  logic [pcpu_pkg::TAP_N-1:0][pcpu_pkg::CHAR_W-1:0] new_taps;
  logic [1:0] before_cnt;
  logic [1:0] after_cnt;

  // hit counts over the qualified windows, old and new contents
  always_comb begin
    new_taps = win_i.taps;
    new_taps[pcpu_pkg::CENTER_TAP] = new_char_i;
    before_cnt = '0;
    after_cnt  = '0;
    for (int w = 0; w < pcpu_pkg::WIN_N; w++) begin
      if (win_i.valid[w] &&
          pcpu_pkg::is_abc(win_i.taps[w], win_i.taps[w+1], win_i.taps[w+2])) begin
        before_cnt = before_cnt + 2'd1;
      end
      if (win_i.valid[w] &&
          pcpu_pkg::is_abc(new_taps[w], new_taps[w+1], new_taps[w+2])) begin
        after_cnt = after_cnt + 2'd1;
      end
    end
  end

  // signed difference, range -3..3
  assign delta_o = $signed({1'b0, after_cnt}) - $signed({1'b0, before_cnt});

endmodule

### rtl/pattern_count_point_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_count_point_update_unit
// Byte store with a running count of ABC occurrences, updated per written byte.
// ----------------------------------------------------------------------------
// In-range write: five reads through the registered read port, then the
// write-back; busy stays high until the write-back, so no new write is taken
// before the last is through, and the result strobe is registered from it.
// Out-of-range position: result strobe the next cycle, one item per cycle.
// After reset the store is swept to zero with busy high; configuration
// writes are taken during the sweep. Results are never stalled.
module pattern_count_point_update_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beat
  input  logic                          start,
  output logic                          busy,
  input  pcpu_pkg::in_t                 in_data,
  // result beat
  output logic                          out_valid,
  output pcpu_pkg::out_t                out_data,
  // length register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcpu_pkg::LEN_W-1:0]    cfg_data
);

  localparam int AW = pcpu_pkg::ADDR_W;
  localparam int LW = pcpu_pkg::LEN_W;
  localparam int CW = pcpu_pkg::COUNT_W;

  // state and control registers
  pcpu_pkg::state_t              state_r, state_nxt;
  logic [AW-1:0]                 clr_addr_r, clr_addr_nxt;
  logic [pcpu_pkg::TAP_CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [LW-1:0]                 len_r;
  logic                          out_valid_r, out_valid_nxt;

  // payload registers
  logic [AW-1:0]                 pos_r;
  logic [pcpu_pkg::CHAR_W-1:0]   char_r;
  logic [pcpu_pkg::WIN_N-1:0]    win_valid_r;
  logic [pcpu_pkg::TAP_N-1:0][pcpu_pkg::CHAR_W-1:0] taps_r;
  pcpu_pkg::out_t                out_data_r, out_data_nxt;

  // memory
  logic [pcpu_pkg::CHAR_W-1:0]   mem [pcpu_pkg::MAX_LEN];
  logic                          mem_we;
  logic [AW-1:0]                 mem_wr_addr;
  logic [pcpu_pkg::CHAR_W-1:0]   mem_wr_data;
  logic [AW-1:0]                 rd_addr;
  logic [pcpu_pkg::CHAR_W-1:0]   rd_data_r;

  // datapath helpers
  logic [LW-1:0]                 eff_len;
  logic                          accept;
  logic                          in_range;
  logic [pcpu_pkg::WIN_N-1:0]    win_valid_in;
  pcpu_pkg::win_t                win;
  logic signed [2:0]             delta;
  logic signed [CW+1:0]          count_sum;

  // effective length clamps to the store depth
  assign eff_len  = (len_r > LW'(pcpu_pkg::MAX_LEN)) ? LW'(pcpu_pkg::MAX_LEN) : len_r;
  assign accept   = start && !busy;
  assign in_range = {1'b0, in_data.position} < eff_len;

  // window w starts at position-2+w; it must start at or after zero and end
  // below the effective length
  always_comb begin
    for (int w = 0; w < pcpu_pkg::WIN_N; w++) begin
      win_valid_in[w] = ({1'b0, in_data.position} >= LW'(2 - w)) &&
                        (({1'b0, in_data.position} + LW'(w)) < eff_len);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcpu_pkg::S_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = pcpu_pkg::S_IDLE;
      end
      pcpu_pkg::S_IDLE: begin
        if (accept && in_range) state_nxt = pcpu_pkg::S_READ;
      end
      pcpu_pkg::S_READ: begin
        if (rd_cnt_r == pcpu_pkg::TAP_CNT_W'(pcpu_pkg::TAP_N)) state_nxt = pcpu_pkg::S_WRITE;
      end
      pcpu_pkg::S_WRITE: begin
        state_nxt = pcpu_pkg::S_IDLE;
      end
      default: state_nxt = pcpu_pkg::S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    busy        = 1'b1;
    mem_we      = 1'b0;
    mem_wr_addr = pos_r;
    mem_wr_data = char_r;
    rd_addr     = '0;
    unique case (state_r)
      pcpu_pkg::S_CLEAR: begin
        mem_we      = 1'b1;
        mem_wr_addr = clr_addr_r;
        mem_wr_data = '0;
      end
      pcpu_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      pcpu_pkg::S_READ: begin
        rd_addr = pos_r + AW'(rd_cnt_r) - AW'(pcpu_pkg::CENTER_TAP);
      end
      pcpu_pkg::S_WRITE: begin
        mem_we = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // match change over the captured neighborhood
  assign win.taps  = taps_r;
  assign win.valid = win_valid_r;

  pcpu_match_delta u_delta (
    .win_i      (win),
    .new_char_i (char_r),
    .delta_o    (delta)
  );

  assign count_sum = $signed({2'b00, count_r}) + $signed({{(CW-1){delta[2]}}, delta});

  // counters, count update and result
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    rd_cnt_nxt    = rd_cnt_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      pcpu_pkg::S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      pcpu_pkg::S_IDLE: begin
        rd_cnt_nxt = '0;
        if (accept && !in_range) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.match_count = count_r;
          out_data_nxt.ignored     = 1'b1;
        end
      end
      pcpu_pkg::S_READ: begin
        rd_cnt_nxt = rd_cnt_r + pcpu_pkg::TAP_CNT_W'(1);
      end
      pcpu_pkg::S_WRITE: begin
        if (count_sum < 0) begin
          count_nxt = '0;
        end else if (count_sum > $signed({2'b00, pcpu_pkg::COUNT_MAX})) begin
          count_nxt = pcpu_pkg::COUNT_MAX;
        end else begin
          count_nxt = count_sum[CW-1:0];
        end
        out_valid_nxt            = 1'b1;
        out_data_nxt.match_count = count_nxt;
        out_data_nxt.ignored     = 1'b0;
      end
      default: clr_addr_nxt = clr_addr_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcpu_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      rd_cnt_r    <= '0;
      count_r     <= '0;
      len_r       <= LW'(pcpu_pkg::MAX_LEN);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) len_r <= cfg_data;
    end
  end

  // payload capture: request on accept, neighborhood bytes one read later
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      pos_r       <= in_data.position;
      char_r      <= in_data.new_char;
      win_valid_r <= win_valid_in;
    end
    if (state_r == pcpu_pkg::S_READ && rd_cnt_r != '0) begin
      taps_r[rd_cnt_r - pcpu_pkg::TAP_CNT_W'(1)] <= rd_data_r;
    end
  end

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wr_addr] <= mem_wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no result while the store is being swept
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcpu_pkg::S_CLEAR) |-> !out_valid_r)
    else $error("result beat during clearing sweep");

  // every write-back produces exactly one in-range result
  a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcpu_pkg::S_WRITE) |=> (out_valid_r && !out_data_r.ignored))
    else $error("write-back without in-range result");

  // count moves only on write-back
  a_count_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> ($past(state_r) == pcpu_pkg::S_WRITE))
    else $error("count changed outside write-back");

  // ignored results come straight from an idle accept
  a_ignored_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.ignored) |-> ($past(state_r) == pcpu_pkg::S_IDLE))
    else $error("ignored result not from idle accept");

endmodule

### dv/pattern_count_point_update_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_count_point_update_unit_tb
// Self-checking bench for the ABC occurrence counter. Every accepted write
// beat is run through a local model of the byte store and running count, and
// each result beat is checked against the oldest predicted count. Directed
// tests cover the count floor and the store/length edges; the random part
// builds and breaks ABC windows under changing lengths.
// ----------------------------------------------------------------------------
module pattern_count_point_update_unit_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 1500;
  localparam int CALM_START  = 1200;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  pcpu_pkg::in_t                 in_data;
  logic                          out_valid;
  pcpu_pkg::out_t                out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pcpu_pkg::LEN_W-1:0]    cfg_data;

  // local copy of the store, the count and the length register
  logic [pcpu_pkg::CHAR_W-1:0]   stored_text [0:pcpu_pkg::MAX_LEN-1];
  logic [pcpu_pkg::COUNT_W-1:0]  match_total;
  logic [pcpu_pkg::LEN_W-1:0]    text_len;

  pcpu_pkg::out_t                pending_counts[$];
  int                            sent_items;
  int                            errors;
  int                            cycle_count;
  bit                            idle_on;

  pattern_count_point_update_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ABC windows starting in [pos-2, pos] that fit below len
  function automatic int unsigned abc_windows(int unsigned pos, int unsigned len);
    int unsigned first;
    int unsigned hits;
    first = (pos >= 2) ? pos - 2 : 0;
    hits = 0;
    for (int unsigned j = first; j <= pos; j++) begin
      if (j + 2 >= len)
        break;
      if (stored_text[j] == pcpu_pkg::PAT0 && stored_text[j+1] == pcpu_pkg::PAT1 &&
          stored_text[j+2] == pcpu_pkg::PAT2)
        hits++;
    end
    return hits;
  endfunction

  // apply one write to the local store and return the expected result beat
  function automatic pcpu_pkg::out_t apply_char_write(pcpu_pkg::in_t item);
    int unsigned len;
    int unsigned pos;
    int unsigned before_hits;
    int unsigned after_hits;
    int unsigned sum;
    pcpu_pkg::out_t res;
    len = (text_len > pcpu_pkg::MAX_LEN) ? pcpu_pkg::MAX_LEN : text_len;
    pos = item.position;
    res.ignored = 1'b1;
    if (pos < len) begin
      before_hits = abc_windows(pos, len);
      stored_text[pos] = item.new_char;
      after_hits = abc_windows(pos, len);
      if (after_hits >= before_hits) begin
        sum = match_total + (after_hits - before_hits);
        match_total = (sum > pcpu_pkg::COUNT_MAX) ? pcpu_pkg::COUNT_MAX
                                                  : sum[pcpu_pkg::COUNT_W-1:0];
      end else if (match_total >= before_hits - after_hits) begin
        match_total = pcpu_pkg::COUNT_W'(match_total - (before_hits - after_hits));
      end else begin
        match_total = '0;
      end
      res.ignored = 1'b0;
    end
    res.match_count = match_total;
    return res;
  endfunction

  // result beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_counts.size() == 0) begin
        $error("result beat with no write pending: match_count %0d ignored %0b",
               out_data.match_count, out_data.ignored);
        errors++;
      end else begin
        pcpu_pkg::out_t exp_beat;
        exp_beat = pending_counts.pop_front();
        if (out_data.match_count !== exp_beat.match_count) begin
          $error("match_count: expected %0d, actual %0d",
                 exp_beat.match_count, out_data.match_count);
          errors++;
        end
        if (out_data.ignored !== exp_beat.ignored) begin
          $error("ignored: expected %0b, actual %0b", exp_beat.ignored, out_data.ignored);
          errors++;
        end
      end
    end
  end

  // send one write beat, with an optional idle burst in front
  task automatic write_char(input logic [pcpu_pkg::ADDR_W-1:0] pos,
                            input logic [pcpu_pkg::CHAR_W-1:0] ch);
    int gap;
    pcpu_pkg::in_t item;
    item.position = pos;
    item.new_char = ch;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 5);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    pending_counts.push_back(apply_char_write(item));
    sent_items++;
  endtask

  // stop sending and wait for every predicted result
  task automatic wait_results_done();
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  // length register write
  task automatic set_text_length(input logic [pcpu_pkg::LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    text_len = len;
  endtask

  // count floor: break a window that was never counted while the count is zero
  task automatic test_count_floor();
    idle_on = 1'b1;
    set_text_length(13);
    write_char(12, pcpu_pkg::PAT2);
    wait_results_done();
    set_text_length(12);
    write_char(10, pcpu_pkg::PAT0);
    write_char(11, pcpu_pkg::PAT1);
    wait_results_done();
    set_text_length(13);
    write_char(11, 8'h58);
    write_char(11, 8'h00);
    wait_results_done();
  endtask

  // store edges, out-of-range positions, windows past the end, short lengths
  task automatic test_directed_edges();
    set_text_length(pcpu_pkg::LEN_W'(pcpu_pkg::MAX_LEN));
    write_char(0, pcpu_pkg::PAT0);
    write_char(1, pcpu_pkg::PAT1);
    write_char(2, pcpu_pkg::PAT2);
    write_char(4095, pcpu_pkg::PAT2);
    write_char(4094, pcpu_pkg::PAT1);
    write_char(4093, pcpu_pkg::PAT0);
    write_char(1, 8'hFF);
    write_char(1, pcpu_pkg::PAT1);
    wait_results_done();
    // above the store size acts as the full store
    set_text_length(13'h1FFF);
    write_char(4095, 8'h00);
    wait_results_done();
    set_text_length(100);
    write_char(100, pcpu_pkg::PAT0);
    write_char(4095, 8'hFF);
    write_char(97, pcpu_pkg::PAT0);
    write_char(98, pcpu_pkg::PAT1);
    write_char(99, pcpu_pkg::PAT2);
    wait_results_done();
    set_text_length(99);
    write_char(98, 8'h58);
    wait_results_done();
    // too short for any window
    set_text_length(2);
    write_char(0, pcpu_pkg::PAT0);
    write_char(1, pcpu_pkg::PAT1);
    write_char(2, pcpu_pkg::PAT2);
    wait_results_done();
    set_text_length(0);
    write_char(0, 8'hFF);
    wait_results_done();
    set_text_length(1);
    write_char(0, pcpu_pkg::PAT0);
    wait_results_done();
    set_text_length(3);
    write_char(1, 8'h00);
    wait_results_done();
  endtask

  // random phases: pick a length, then mostly pattern bytes around a moving spot
  task automatic test_random_updates();
    int unsigned eff;
    int unsigned beats;
    int unsigned base;
    int unsigned mode;
    logic [pcpu_pkg::LEN_W-1:0] len;
    logic [pcpu_pkg::ADDR_W-1:0] pos;
    logic [pcpu_pkg::CHAR_W-1:0] ch;
    while (sent_items < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0: len = pcpu_pkg::LEN_W'(pcpu_pkg::MAX_LEN);
        1: len = 13'h1FFF;
        2: len = pcpu_pkg::LEN_W'($urandom_range(3, 40));
        3: len = pcpu_pkg::LEN_W'($urandom_range(0, 2));
        4: len = pcpu_pkg::LEN_W'($urandom_range(0, 8191));
        5: len = pcpu_pkg::LEN_W'($urandom_range(3, 300));
        6: len = pcpu_pkg::LEN_W'(pcpu_pkg::MAX_LEN - 1);
        default: len = pcpu_pkg::LEN_W'($urandom_range(3, pcpu_pkg::MAX_LEN));
      endcase
      // no idling over the last stretch
      idle_on = (sent_items < CALM_START) && ($urandom_range(0, 2) != 0);
      set_text_length(len);
      eff = (len > pcpu_pkg::MAX_LEN) ? pcpu_pkg::MAX_LEN : len;
      beats = (eff < 3) ? 10 : 100;
      base = 0;
      for (int unsigned n = 0; n < beats; n++) begin
        if (n % 20 == 0)
          base = (eff < 3) ? 0 : $urandom_range(0, eff - 1);
        mode = $urandom_range(0, 9);
        if (mode <= 5)
          pos = pcpu_pkg::ADDR_W'(base + $urandom_range(0, 7));
        else if (mode <= 7 && eff >= 3)
          pos = pcpu_pkg::ADDR_W'(eff - 3 + $urandom_range(0, 5));
        else
          pos = pcpu_pkg::ADDR_W'($urandom_range(0, pcpu_pkg::MAX_LEN - 1));
        if ($urandom_range(0, 3) != 0)
          ch = pcpu_pkg::CHAR_W'(pcpu_pkg::PAT0 + $urandom_range(0, 2));
        else
          ch = pcpu_pkg::CHAR_W'($urandom_range(0, 255));
        write_char(pos, ch);
      end
      wait_results_done();
    end
  endtask

  // main sequence
  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_data          = '0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    match_total      = '0;
    text_len         = pcpu_pkg::LEN_W'(pcpu_pkg::MAX_LEN);
    sent_items       = 0;
    errors           = 0;
    cycle_count      = 0;
    idle_on          = 1'b0;
    for (int i = 0; i < pcpu_pkg::MAX_LEN; i++)
      stored_text[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_count_floor();
    test_directed_edges();
    test_random_updates();

    wait_results_done();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_counts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
